FILE: hw/rtl/partition_f_measure_defines.svh
// Assertion macros for the partition F-measure block.
// Each macro expects clk and arst_n in scope.
`ifndef PARTITION_F_MEASURE_DEFINES_SVH
`define PARTITION_F_MEASURE_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define PFM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfm assertion failed");
// Antecedent implies consequent in the next cycle.
`define PFM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfm assertion failed");
`else
`define PFM_ASSERT_SAME(label, ante, cons)
`define PFM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/pfm_pkg.sv
`default_nettype none
package pfm_pkg;

	localparam int DEF_PRED_CLASSES = 16;
	localparam int DEF_REF_CLASSES  = 16;
	localparam int DEF_COUNT_BITS   = 20;
	localparam int DEF_FRAC_BITS    = 16;

	localparam int LABEL_W = 4;
	localparam int FM_W    = 17;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [PADDR_W-1:0] ADDR_IGNORE_LOWEST_REF = 3'd0;

	// Commands from controller to datapath
	typedef struct packed {
		logic sel_in;
		logic take_add;
		logic wr_add;
		logic clr_wr;
		logic idx_zero;
		logic j_inc;
		logic row_next;
		logic rd_skip;
		logic tot_ld;
		logic acc_zero;
		logic row_ld;
		logic div_cell;
		logic best_upd;
		logic mul;
		logic div_term;
		logic acc_add;
		logic out_ld;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic add_ok;
		logic row_skip;
		logic m_zero;
		logic tot_zero;
		logic div_done;
		logic j_last;
		logic i_last;
		logic j_ones;
		logic i_ones;
	} sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pfm_div.sv
`default_nettype none
module pfm_div import pfm_pkg::*; #(
	parameter int COUNT_BITS = DEF_COUNT_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [COUNT_BITS+FRAC_BITS:0]       num,
	input  wire logic [COUNT_BITS:0]                 den,
	output logic                                     done,
	output logic [FRAC_BITS:0]                       quo
);
	localparam int NW = COUNT_BITS + FRAC_BITS + 1;
	localparam int DW = COUNT_BITS + 1;
	localparam int QW = FRAC_BITS + 1;
	localparam int CW = $clog2(QW + 1);

	logic [DW:0]   rem_q;
	logic [QW-1:0] nlo_q;
	logic [QW-1:0] q_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	// One quotient bit per cycle, restoring
	always_comb begin
		trial = {rem_q[DW-1:0], nlo_q[QW-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (DW+1)'(num[NW-1:QW]);
			nlo_q <= num[QW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff : trial;
			q_q   <= {q_q[QW-2:0], ge};
			nlo_q <= nlo_q << 1;
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule
`default_nettype wire

FILE: hw/rtl/pfm_dp.sv
`default_nettype none
module pfm_dp import pfm_pkg::*; #(
	parameter int PRED_CLASSES = DEF_PRED_CLASSES,
	parameter int REF_CLASSES  = DEF_REF_CLASSES,
	parameter int COUNT_BITS   = DEF_COUNT_BITS,
	parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire logic [LABEL_W-1:0] pred_label,
	input  wire logic [LABEL_W-1:0] ref_label,
	input  wire logic               ignore_lowest_ref,
	output logic [FM_W-1:0]         f_measure,
	output logic                    overflow,
	output logic                    empty_set
);
	localparam int PW     = $clog2(PRED_CLASSES);
	localparam int RW     = $clog2(REF_CLASSES);
	localparam int AW     = PW + RW;
	localparam int DEPTH  = 2 ** AW;
	localparam int PDEPTH = 2 ** PW;
	localparam int RDEPTH = 2 ** RW;
	localparam int NW     = COUNT_BITS + FRAC_BITS + 1;
	localparam int DW     = COUNT_BITS + 1;
	localparam int QW     = FRAC_BITS + 1;

	logic [COUNT_BITS-1:0] cnt_mem [DEPTH];
	logic [COUNT_BITS-1:0] row_mem [RDEPTH];
	logic [COUNT_BITS-1:0] col_mem [PDEPTH];

	logic [PW-1:0] p_in, p_q, j_q;
	logic [RW-1:0] r_in, r_q, i_q, minref_q;
	logic          lbl_ok, full, skip_en;
	logic          any_q, drop_q;
	logic [COUNT_BITS-1:0] total_q, tot_eff_q, rs_q;
	logic [COUNT_BITS-1:0] m_rd, ms_rd, r_rd, c_rd;
	logic [AW-1:0] a_addr, b_addr, w_addr;
	logic [RW-1:0] r_addr, rw_addr;
	logic [PW-1:0] c_addr, cw_addr;
	logic [COUNT_BITS-1:0] m_wd, r_wd, c_wd;
	logic          mem_we;
	logic [QW-1:0] best_q, acc_q, quo;
	logic [NW-1:0] prod_s1, div_num;
	logic [DW-1:0] div_den, den_cell;
	logic          div_start, div_done;
	logic [FM_W-1:0] f_q;
	logic          ovf_q, empty_q;

	// Decode the incoming labels
	always_comb begin
		p_in    = PW'(pred_label);
		r_in    = RW'(ref_label);
		lbl_ok  = (32'(pred_label) < PRED_CLASSES) && (32'(ref_label) < REF_CLASSES);
		full    = &total_q;
		skip_en = ignore_lowest_ref & any_q;
	end

	// Select read and write addresses
	always_comb begin
		a_addr = cmd.sel_in ? {r_in, p_in} : {i_q, j_q};
		b_addr = {minref_q, j_q};
		r_addr = cmd.rd_skip ? minref_q : (cmd.sel_in ? r_in : i_q);
		c_addr = cmd.sel_in ? p_in : j_q;
		mem_we = cmd.clr_wr | cmd.wr_add;
		if (cmd.clr_wr) begin
			w_addr  = {i_q, j_q};
			rw_addr = i_q;
			cw_addr = j_q;
			m_wd    = '0;
			r_wd    = '0;
			c_wd    = '0;
		end else begin
			w_addr  = {r_q, p_q};
			rw_addr = r_q;
			cw_addr = p_q;
			m_wd    = m_rd + 1'b1;
			r_wd    = r_rd + 1'b1;
			c_wd    = c_rd + 1'b1;
		end
	end

	// Joint count memory, two read ports
	always_ff @(posedge clk) begin
		if (mem_we)
			cnt_mem[w_addr] <= m_wd;
		m_rd  <= cnt_mem[a_addr];
		ms_rd <= cnt_mem[b_addr];
	end

	// Reference class counts
	always_ff @(posedge clk) begin
		if (mem_we)
			row_mem[rw_addr] <= r_wd;
		r_rd <= row_mem[r_addr];
	end

	// Predicted class counts
	always_ff @(posedge clk) begin
		if (mem_we)
			col_mem[cw_addr] <= c_wd;
		c_rd <= col_mem[c_addr];
	end

	// Sample bookkeeping and table walk indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			drop_q   <= 1'b0;
			any_q    <= 1'b0;
			minref_q <= '0;
			i_q      <= '0;
			j_q      <= '0;
		end else begin
			if (cmd.clr_wr) begin
				total_q  <= '0;
				drop_q   <= 1'b0;
				any_q    <= 1'b0;
				minref_q <= '0;
			end
			if (cmd.take_add && lbl_ok && full)
				drop_q <= 1'b1;
			if (cmd.wr_add) begin
				total_q <= total_q + 1'b1;
				any_q   <= 1'b1;
				if (!any_q || r_q < minref_q)
					minref_q <= r_q;
			end
			if (cmd.idx_zero) begin
				i_q <= '0;
				j_q <= '0;
			end else if (cmd.row_next) begin
				i_q <= i_q + 1'b1;
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	// Divider operands
	always_comb begin
		den_cell  = DW'(c_rd) - DW'(skip_en ? ms_rd : '0) + DW'(rs_q);
		div_start = cmd.div_cell | cmd.div_term;
		if (cmd.div_cell) begin
			div_num = {m_rd, {QW{1'b0}}};
			div_den = den_cell;
		end else begin
			div_num = prod_s1;
			div_den = DW'(tot_eff_q);
		end
	end

	pfm_div #(
		.COUNT_BITS (COUNT_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	// Accumulate row bests and weighted terms
	always_ff @(posedge clk) begin
		if (cmd.take_add) begin
			p_q <= p_in;
			r_q <= r_in;
		end
		if (cmd.tot_ld)
			tot_eff_q <= total_q - (skip_en ? r_rd : '0);
		if (cmd.row_ld) begin
			rs_q   <= r_rd;
			best_q <= '0;
		end
		if (cmd.best_upd && quo > best_q)
			best_q <= quo;
		if (cmd.mul)
			prod_s1 <= {{COUNT_BITS{1'b0}}, best_q} * {{QW{1'b0}}, rs_q};
		if (cmd.acc_zero)
			acc_q <= '0;
		else if (cmd.acc_add)
			acc_q <= acc_q + quo;
		if (cmd.out_ld) begin
			f_q     <= FM_W'(acc_q);
			ovf_q   <= drop_q;
			empty_q <= (tot_eff_q == '0);
		end
	end

	// Report status
	always_comb begin
		sts.add_ok   = lbl_ok & ~full;
		sts.row_skip = (r_rd == '0) | (skip_en & (i_q == minref_q));
		sts.m_zero   = (m_rd == '0);
		sts.tot_zero = (tot_eff_q == '0);
		sts.div_done = div_done;
		sts.j_last   = (j_q == PW'(PRED_CLASSES - 1));
		sts.i_last   = (i_q == RW'(REF_CLASSES - 1));
		sts.j_ones   = &j_q;
		sts.i_ones   = &i_q;
	end

	assign f_measure = f_q;
	assign overflow  = ovf_q;
	assign empty_set = empty_q;

endmodule
`default_nettype wire

FILE: hw/rtl/pfm_ctrl.sv
`default_nettype none
module pfm_ctrl import pfm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic opcode,
	input  wire logic out_stall,
	output logic      in_stall,
	output logic      out_valid,
	output cmd_t      cmd,
	input  wire sts_t sts
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ADD_WR, S_FIN_RS, S_FIN_TOT, S_FIN_CHK,
		S_ROW_RD, S_ROW_CHK, S_CELL_RD, S_CELL_CHK, S_CELL_DIV,
		S_ROW_MUL, S_ROW_DIV0, S_ROW_DIV, S_OUT_LD, S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.i_ones && sts.j_ones)
					state_d = S_IDLE;
				else if (sts.j_ones)
					cmd.row_next = 1'b1;
				else
					cmd.j_inc = 1'b1;
			end
			S_IDLE: begin
				cmd.sel_in = 1'b1;
				if (in_valid) begin
					if (opcode == OP_FINISH) begin
						state_d = S_FIN_RS;
					end else begin
						cmd.take_add = 1'b1;
						if (sts.add_ok)
							state_d = S_ADD_WR;
					end
				end
			end
			S_ADD_WR: begin
				cmd.wr_add = 1'b1;
				state_d    = S_IDLE;
			end
			S_FIN_RS: begin
				cmd.rd_skip  = 1'b1;
				cmd.idx_zero = 1'b1;
				cmd.acc_zero = 1'b1;
				state_d      = S_FIN_TOT;
			end
			S_FIN_TOT: begin
				cmd.tot_ld = 1'b1;
				state_d    = S_FIN_CHK;
			end
			S_FIN_CHK: state_d = sts.tot_zero ? S_OUT_LD : S_ROW_RD;
			S_ROW_RD:  state_d = S_ROW_CHK;
			S_ROW_CHK: begin
				cmd.row_ld = 1'b1;
				if (!sts.row_skip) begin
					state_d = S_CELL_RD;
				end else if (sts.i_last) begin
					state_d = S_OUT_LD;
				end else begin
					cmd.row_next = 1'b1;
					state_d      = S_ROW_RD;
				end
			end
			S_CELL_RD: state_d = S_CELL_CHK;
			S_CELL_CHK: begin
				if (!sts.m_zero) begin
					cmd.div_cell = 1'b1;
					state_d      = S_CELL_DIV;
				end else if (sts.j_last) begin
					state_d = S_ROW_MUL;
				end else begin
					cmd.j_inc = 1'b1;
					state_d   = S_CELL_RD;
				end
			end
			S_CELL_DIV: begin
				if (sts.div_done) begin
					cmd.best_upd = 1'b1;
					if (sts.j_last) begin
						state_d = S_ROW_MUL;
					end else begin
						cmd.j_inc = 1'b1;
						state_d   = S_CELL_RD;
					end
				end
			end
			S_ROW_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ROW_DIV0;
			end
			S_ROW_DIV0: begin
				cmd.div_term = 1'b1;
				state_d      = S_ROW_DIV;
			end
			S_ROW_DIV: begin
				if (sts.div_done) begin
					cmd.acc_add = 1'b1;
					if (sts.i_last) begin
						state_d = S_OUT_LD;
					end else begin
						cmd.row_next = 1'b1;
						state_d      = S_ROW_RD;
					end
				end
			end
			S_OUT_LD: begin
				cmd.out_ld = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_stall) begin
					cmd.idx_zero = 1'b1;
					state_d      = S_CLEAR;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// Hold state and the result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (state_d == S_DONE);
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: hw/rtl/partition_f_measure.sv
// Clustering F-measure of a predicted partition against a reference one.
// Input channel (in_valid/in_stall): opcode add counts one (pred_label,
// ref_label) pair in a joint count table; opcode finish emits one result.
// Output channel (out_valid/out_stall): f_measure with FRAC_BITS fraction
// bits, overflow (samples dropped at capacity) and empty_set.
// An add item reads the count memories and then writes them back
// incremented. A finish walks the table row by row: for each present
// reference row every nonzero cell goes through the shared bit-serial
// divider to find the row best, then the weighted term goes through the
// same divider. The result is held in the output register until taken;
// while the receiver stalls, input stays stalled. Once the result is
// taken the table is swept to zero, and the same sweep runs after reset;
// no item is accepted during it. The ignore_lowest_ref register lies at
// byte address 0 of the APB port. The user must write it only while the
// block is idle; the block itself does not enforce this.
`default_nettype none
`include "partition_f_measure_defines.svh"
module partition_f_measure import pfm_pkg::*; #(
	parameter int PRED_CLASSES = DEF_PRED_CLASSES,
	parameter int REF_CLASSES  = DEF_REF_CLASSES,
	parameter int COUNT_BITS   = DEF_COUNT_BITS,
	parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               opcode,
	input  wire logic [LABEL_W-1:0] pred_label,
	input  wire logic [LABEL_W-1:0] ref_label,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [FM_W-1:0]         f_measure,
	output logic                    overflow,
	output logic                    empty_set,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);
	cmd_t cmd;
	sts_t sts;
	logic ignore_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ignore_q <= 1'b0;
		else if (psel && penable && pwrite && paddr == ADDR_IGNORE_LOWEST_REF)
			ignore_q <= pwdata[0];
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_IGNORE_LOWEST_REF) ? PDATA_W'(ignore_q) : '0;

	pfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	pfm_dp #(
		.PRED_CLASSES (PRED_CLASSES),
		.REF_CLASSES  (REF_CLASSES),
		.COUNT_BITS   (COUNT_BITS),
		.FRAC_BITS    (FRAC_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.pred_label        (pred_label),
		.ref_label         (ref_label),
		.ignore_lowest_ref (ignore_q),
		.f_measure         (f_measure),
		.overflow          (overflow),
		.empty_set         (empty_set)
	);

	// Input is only taken while no result is pending
	`PFM_ASSERT_SAME(a_idle_no_result, !in_stall, !out_valid)
	// A finish item closes the input until the table is swept
	`PFM_ASSERT_NEXT(a_finish_stalls, in_valid && !in_stall && opcode == OP_FINISH, in_stall)
	// An empty set always reports zero
	`PFM_ASSERT_SAME(a_empty_zero, out_valid && empty_set, f_measure == '0)

endmodule
`default_nettype wire
